@@ src/itr_pkg.sv @@
// ============================================================================
// itr_pkg
// Shared types, constants and the control store of the Roman numeral encoder.
// ============================================================================
package itr_pkg;

    localparam int unsigned NumberWidth = 12;
    localparam int unsigned CharWidth   = 7;
    localparam int unsigned PcWidth     = 4;

    localparam logic [NumberWidth-1:0] MaxValue = NumberWidth'(3999);

    localparam logic [CharWidth-1:0] CharNone = 7'h00;
    localparam logic [CharWidth-1:0] CharI    = 7'h49;
    localparam logic [CharWidth-1:0] CharV    = 7'h56;
    localparam logic [CharWidth-1:0] CharX    = 7'h58;
    localparam logic [CharWidth-1:0] CharL    = 7'h4C;
    localparam logic [CharWidth-1:0] CharC    = 7'h43;
    localparam logic [CharWidth-1:0] CharD    = 7'h44;
    localparam logic [CharWidth-1:0] CharM    = 7'h4D;

    typedef logic [PcWidth-1:0] pc_t;

    // One step of the program: subtract weight while it fits, emitting
    // first_char then (if nonzero) second_char; else jump to jump_pc.
    typedef struct packed {
        logic [NumberWidth-1:0] weight;
        logic [CharWidth-1:0]   first_char;
        logic [CharWidth-1:0]   second_char;
        pc_t                    jump_pc;
    } ctrl_word_t;

    function automatic ctrl_word_t ctrl_rom(input pc_t pc);
        ctrl_word_t cw;
        unique case (pc)
            4'd0:    cw = '{12'd1000, CharM, CharNone, 4'd1};
            4'd1:    cw = '{12'd900,  CharC, CharM,    4'd2};
            4'd2:    cw = '{12'd500,  CharD, CharNone, 4'd3};
            4'd3:    cw = '{12'd400,  CharC, CharD,    4'd4};
            4'd4:    cw = '{12'd100,  CharC, CharNone, 4'd5};
            4'd5:    cw = '{12'd90,   CharX, CharC,    4'd6};
            4'd6:    cw = '{12'd50,   CharL, CharNone, 4'd7};
            4'd7:    cw = '{12'd40,   CharX, CharL,    4'd8};
            4'd8:    cw = '{12'd10,   CharX, CharNone, 4'd9};
            4'd9:    cw = '{12'd9,    CharI, CharX,    4'd10};
            4'd10:   cw = '{12'd5,    CharV, CharNone, 4'd11};
            4'd11:   cw = '{12'd4,    CharI, CharV,    4'd12};
            4'd12:   cw = '{12'd1,    CharI, CharNone, 4'd12};
            default: cw = '{12'd1,    CharI, CharNone, 4'd12};
        endcase
        return cw;
    endfunction

endpackage

@@ src/integer_to_roman_encoder.sv @@
// ============================================================================
// integer_to_roman_encoder
// Converts a 12-bit unsigned number to its Roman numeral, one ASCII
// character per output transfer, driven by a small microcoded sequencer.
// ============================================================================
//
// Channel   Dir  tdata                        tlast      tuser
// s_*       in   [11:0] number_in             -          -
// m_*       out  [6:0] symbol_char            last_char  range_error
//
// After the accept, the sequencer takes one step per character and one per
// skipped table step (3888 gives 15 characters and 12 skipped steps), as the
// step counter walks the 13-entry control store. An out-of-range input (zero
// or above 3999) loads one error transfer at the accept edge. A new
// number is taken once the last character sits in the output register and
// that register is free or draining. A stalled output holds the sequencer.
// Reset clears all control.

module integer_to_roman_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] number_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] symbol_char
    output logic        m_tlast,   // last_char
    output logic        m_tuser    // range_error
);

    logic                                 busy_reg, busy_next;
    logic                                 pair_reg, pair_next;
    itr_pkg::pc_t                         pc_reg, pc_next;
    logic [itr_pkg::NumberWidth-1:0]      rest_reg, rest_next;
    logic                                 m_tvalid_reg, m_tvalid_next;
    logic [itr_pkg::CharWidth-1:0]        char_reg, char_next;
    logic                                 last_reg, last_next;
    logic                                 err_reg, err_next;

    itr_pkg::ctrl_word_t                  cw;
    logic [itr_pkg::NumberWidth-1:0]      number_in;
    logic [itr_pkg::NumberWidth-1:0]      diff;
    logic                                 slot_free;
    logic                                 fits;

    assign number_in = s_tdata[itr_pkg::NumberWidth-1:0];
    assign slot_free = !m_tvalid_reg || m_tready;
    assign s_tready  = !busy_reg && slot_free;
    assign cw        = itr_pkg::ctrl_rom(pc_reg);
    assign fits      = rest_reg >= cw.weight;
    assign diff      = rest_reg - cw.weight;

    always_comb
    begin
        busy_next     = busy_reg;
        pair_next     = pair_reg;
        pc_next       = pc_reg;
        rest_next     = rest_reg;
        m_tvalid_next = m_tvalid_reg;
        char_next     = char_reg;
        last_next     = last_reg;
        err_next      = err_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (s_tvalid && s_tready)
        begin
            if (number_in == '0 || number_in > itr_pkg::MaxValue)
            begin
                m_tvalid_next = 1'b1;
                char_next     = itr_pkg::CharNone;
                last_next     = 1'b1;
                err_next      = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
                rest_next = number_in;
                pc_next   = '0;
                pair_next = 1'b0;
            end
        end
        else if (busy_reg && slot_free)
        begin
            if (!fits)
            begin
                pc_next = cw.jump_pc;
            end
            else if (!pair_reg)
            begin
                m_tvalid_next = 1'b1;
                char_next     = cw.first_char;
                err_next      = 1'b0;
                if (cw.second_char != itr_pkg::CharNone)
                begin
                    pair_next = 1'b1;
                    last_next = 1'b0;
                end
                else
                begin
                    rest_next = diff;
                    last_next = (diff == '0);
                    busy_next = (diff != '0);
                end
            end
            else
            begin
                m_tvalid_next = 1'b1;
                char_next     = cw.second_char;
                err_next      = 1'b0;
                pair_next     = 1'b0;
                rest_next     = diff;
                last_next     = (diff == '0);
                busy_next     = (diff != '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            pair_reg     <= 1'b0;
            pc_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            pair_reg     <= pair_next;
            pc_reg       <= pc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rest_reg <= rest_next;
        char_reg <= char_next;
        last_reg <= last_next;
        err_reg  <= err_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = err_reg;

endmodule
